// File: rtl/core/agcm_pkg.sv
// Shared constants, types and functions of the AES-128-GCM engine.
package agcm_pkg;

   localparam int BlockWidth  = 128;
   localparam int CountWidth  = 5;
   localparam int NumRounds   = 10;
   localparam int GhashDigits = 8;   // bits of the multiplier folded per cycle

   localparam logic [1:0] FUNC_AAD    = 2'd0;
   localparam logic [1:0] FUNC_TEXT   = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   localparam logic [2:0] CSR_KEY_HIGH  = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW   = 3'd1;
   localparam logic [2:0] CSR_NONCE_HI  = 3'd2;
   localparam logic [2:0] CSR_NONCE_LO  = 3'd3;
   localparam logic [2:0] CSR_ENCRYPT   = 3'd4;
   localparam logic [2:0] CSR_TAG_HIGH  = 3'd5;
   localparam logic [2:0] CSR_TAG_LOW   = 3'd6;

   localparam logic [7:0] GhashPoly = 8'd225;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Control from the sequencer to the AES round unit
   typedef struct packed {
      logic         start;
      logic [127:0] block;
   } aes_ctl_type;

   // Control from the sequencer to the GHASH multiplier
   typedef struct packed {
      logic         start;
      logic [127:0] operand;
      logic [127:0] subkey;
   } gmul_ctl_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Keep the leading n bytes of a 128-bit block (byte 0 in the top bits)
   function automatic logic [127:0] keep_leading(input logic [127:0] b,
                                                 input logic [4:0] n);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < n) m[127 - 8*i -: 8] = 8'hff;
      end
      keep_leading = b & m;
   endfunction

endpackage

// File: rtl/core/agcm_key_exp.sv
// AES-128 key schedule: one round key per cycle into an eleven-entry store.
module agcm_key_exp (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] key,
   input  logic [3:0]   rd_round,
   output logic [127:0] rd_key,
   output logic         busy
);

   logic [127:0] round_key_store [11];
   logic [127:0] cur_ff, cur_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   idx_ff, idx_in;
   logic         busy_ff, busy_in;
   logic [31:0]  w0, w1, w2, w3, t;

   // Derive the next round key from the current one
   always_comb begin
      t  = {agcm_pkg::SBOX[cur_ff[23:16]] ^ rcon_ff, agcm_pkg::SBOX[cur_ff[15:8]],
            agcm_pkg::SBOX[cur_ff[7:0]], agcm_pkg::SBOX[cur_ff[31:24]]};
      w0 = cur_ff[127:96] ^ t;
      w1 = cur_ff[95:64] ^ w0;
      w2 = cur_ff[63:32] ^ w1;
      w3 = cur_ff[31:0] ^ w2;
      cur_in  = cur_ff;
      rcon_in = rcon_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (start) begin
         cur_in  = key;
         rcon_in = 8'h01;
         idx_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cur_in  = {w0, w1, w2, w3};
         rcon_in = agcm_pkg::xtime(rcon_ff);
         idx_in  = idx_ff + 4'd1;
         busy_in = (idx_ff != 4'(agcm_pkg::NumRounds));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         rcon_ff <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         rcon_ff <= rcon_in;
      end
      cur_ff <= cur_in;
      if (busy_ff) round_key_store[idx_ff] <= cur_ff;
   end

   assign rd_key = round_key_store[rd_round];
   assign busy   = busy_ff;

endmodule

// File: rtl/core/agcm_aes_round.sv
// Iterative AES-128 encryption: one round per cycle on a shared round unit.
module agcm_aes_round (
   input  logic                  clock,
   input  logic                  reset,
   input  agcm_pkg::aes_ctl_type ctl,
   input  logic [127:0]          round_key,
   output logic [3:0]            round,
   output logic [127:0]          result,
   output logic                  done
);

   logic [127:0] st_ff, st_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [7:0]   s [16];
   logic [7:0]   sh [16];
   logic [7:0]   mx [16];
   logic [127:0] ark, nxt;
   logic [7:0]   a0, a1, a2, a3, al;

   // One round: add key, sub bytes, shift rows, mix columns (skipped in the last round)
   always_comb begin
      ark = st_ff ^ round_key;
      for (int i = 0; i < 16; i++) s[i] = agcm_pkg::SBOX[ark[127 - 8*i -: 8]];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) sh[c*4 + r] = s[((c + r) & 3)*4 + r];
      for (int c = 0; c < 4; c++) begin
         a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         mx[c*4]   = a0 ^ al ^ agcm_pkg::xtime(a0 ^ a1);
         mx[c*4+1] = a1 ^ al ^ agcm_pkg::xtime(a1 ^ a2);
         mx[c*4+2] = a2 ^ al ^ agcm_pkg::xtime(a2 ^ a3);
         mx[c*4+3] = a3 ^ al ^ agcm_pkg::xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++)
         nxt[127 - 8*i -: 8] = (rnd_ff == 4'd9) ? sh[i] : mx[i];
   end

   // Advance one round a cycle; the final key alone is added once the round count reaches ten
   always_comb begin
      st_in   = st_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         st_in   = ctl.block;
         rnd_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rnd_ff == 4'(agcm_pkg::NumRounds)) begin
            st_in   = ark;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            st_in  = nxt;
            rnd_in = rnd_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
      st_ff <= st_in;
   end

   assign round  = rnd_ff;
   assign result = st_ff;
   assign done   = done_ff;

endmodule

// File: rtl/core/agcm_ghash_mul.sv
// GF(2^128) multiplier folding eight multiplier bits per cycle.
module agcm_ghash_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  agcm_pkg::gmul_ctl_type ctl,
   output logic [127:0]           product,
   output logic                   done
);

   localparam int Steps = 128 / agcm_pkg::GhashDigits;

   logic [127:0] z_ff, z_in, v_ff, v_in, x_ff, x_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [127:0] z, v;

   // Shift-and-add over the next eight bits of the operand
   always_comb begin
      z = z_ff;
      v = v_ff;
      for (int i = 0; i < agcm_pkg::GhashDigits; i++) begin
         if (x_ff[127 - i]) z = z ^ v;
         v = {1'b0, v[127:1]} ^ (v[0] ? {agcm_pkg::GhashPoly, 120'd0} : 128'd0);
      end
      z_in = z_ff; v_in = v_ff; x_in = x_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (ctl.start) begin
         z_in = '0; v_in = ctl.subkey; x_in = ctl.operand;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         z_in = z; v_in = v;
         x_in = {x_ff[127 - agcm_pkg::GhashDigits:0], {agcm_pkg::GhashDigits{1'b0}}};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(Steps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      z_ff <= z_in;
      v_ff <= v_in;
      x_ff <= x_in;
   end

   assign product = z_ff;
   assign done    = done_ff;

endmodule

// File: rtl/core/aes128_gcm_engine_unit.sv
// Top level of the AES-128-GCM engine: sequencer, registers and channels.
// Usage: write key, nonce, direction and expected tag on the csr_ channel
// (index 0..6) while idle. Send words on req_: tuser = func, tdata =
// block_high (63:0), block_low (127:64) and byte_count (132:128).
// Additional-data words and empty text words yield nothing; other text
// words yield the processed block; a finish word yields the tag with
// rsp_tuser bit 0 is_tag and bit 1 tag_matches, which is set only when decrypting.
// A text word runs AES on its counter block, then GHASH, and loads its result;
// a finish word runs GHASH over the lengths, then AES on the nonce with counter 1.
// The AES round unit takes 11 steps and the GHASH multiplier 16 steps of eight
// bits, and these set the rate. An additional-data word runs GHASH only, an empty
// text word returns to idle from dispatch and a stray func is dropped. The first
// word after a key write first runs the key schedule and then E(0) for H.
// req_tready is high whenever the sequencer is idle. A finished result
// waits in the sequencer while a stalled receiver still holds the previous
// one in the output register, and no new word is taken meanwhile.
// Reset clears message state, key, nonce and expected tag, selects encryption
// and forces a new key schedule; the round-key store itself is not cleared.
module aes128_gcm_engine_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // block_high, block_low, byte_count, pad
   input  logic [1:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // result_high, result_low, result_bytes, pad
   output logic [1:0]   rsp_tuser,   // is_tag, tag_matches
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   typedef enum logic [3:0] {
      IDLE, KEYS, HKEY_GO, HKEY_WAIT, DISPATCH, AES_WAIT, MUL_GO, MUL_WAIT, FIN_AES, EMIT
   } state_type;

   state_type    state_ff, state_in;
   logic [127:0] key_ff, nonce_ff;
   logic         enc_ff, keys_ready_ff, keys_ready_in;
   logic [127:0] exp_tag_ff;
   logic [127:0] h_ff, h_in, acc_ff, acc_in;
   logic [31:0]  ctr_ff, ctr_in;
   logic [63:0]  aad_tot_ff, aad_tot_in, txt_tot_ff, txt_tot_in;
   logic [1:0]   func_ff, func_in;
   logic [127:0] blk_ff, blk_in, res_ff, res_in;
   logic [4:0]   n_ff, n_in;
   logic         rv_ff, rv_in;
   logic [135:0] rd_ff, rd_in;
   logic [1:0]   ru_ff, ru_in;
   logic         ke_start, ke_busy;
   logic [3:0]   round;
   logic [127:0] rkey, aes_res, prod;
   logic         aes_done, mul_done;
   agcm_pkg::aes_ctl_type  aes_ctl;
   agcm_pkg::gmul_ctl_type mul_ctl;
   logic [4:0]   n_sat;
   logic [127:0] rtxt;
   logic         accept, idle_w;

   agcm_key_exp u_keys (.clock, .reset, .start(ke_start), .key(key_ff),
                        .rd_round(round), .rd_key(rkey), .busy(ke_busy));
   agcm_aes_round u_aes (.clock, .reset, .ctl(aes_ctl), .round_key(rkey),
                         .round, .result(aes_res), .done(aes_done));
   agcm_ghash_mul u_mul (.clock, .reset, .ctl(mul_ctl), .product(prod),
                         .done(mul_done));

   assign idle_w     = (state_ff == IDLE);
   assign req_tready = idle_w;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign n_sat      = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];
   assign rtxt       = agcm_pkg::keep_leading(blk_ff ^ aes_res, n_ff);

   // Sequence one word through key setup, AES and GHASH
   always_comb begin
      state_in = state_ff; keys_ready_in = keys_ready_ff;
      h_in = h_ff; acc_in = acc_ff; ctr_in = ctr_ff;
      aad_tot_in = aad_tot_ff; txt_tot_in = txt_tot_ff;
      func_in = func_ff; blk_in = blk_ff; n_in = n_ff; res_in = res_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff; ru_in = ru_ff;
      ke_start = 1'b0;
      aes_ctl = '{start: 1'b0, block: '0};
      mul_ctl = '{start: 1'b0, operand: acc_ff, subkey: h_ff};
      unique case (state_ff)
         IDLE: if (accept) begin
            func_in = req_tuser;
            n_in    = n_sat;
            blk_in  = agcm_pkg::keep_leading({req_tdata[63:0], req_tdata[127:64]}, n_sat);
            if (req_tuser == 2'd3) state_in = IDLE;
            else if (!keys_ready_ff) begin
               ke_start = 1'b1;
               state_in = KEYS;
            end else state_in = DISPATCH;
         end
         KEYS: if (!ke_busy) state_in = HKEY_GO;
         HKEY_GO: begin
            aes_ctl  = '{start: 1'b1, block: '0};
            state_in = HKEY_WAIT;
         end
         HKEY_WAIT: if (aes_done) begin
            h_in = aes_res;
            keys_ready_in = 1'b1;
            state_in = DISPATCH;
         end
         DISPATCH: begin
            priority if (func_ff == agcm_pkg::FUNC_FINISH) begin
               acc_in   = acc_ff ^ {aad_tot_ff << 3, txt_tot_ff << 3};
               state_in = MUL_GO;
            end else if (n_ff == 5'd0) state_in = IDLE;
            else if (func_ff == agcm_pkg::FUNC_AAD) begin
               acc_in     = acc_ff ^ blk_ff;
               aad_tot_in = aad_tot_ff + 64'(n_ff);
               state_in   = MUL_GO;
            end else begin
               aes_ctl  = '{start: 1'b1, block: {nonce_ff[127:32], ctr_ff}};
               state_in = AES_WAIT;
            end
         end
         AES_WAIT: if (aes_done) begin
            ctr_in     = ctr_ff + 32'd1;
            txt_tot_in = txt_tot_ff + 64'(n_ff);
            res_in     = rtxt;
            acc_in     = acc_ff ^ (enc_ff ? rtxt : blk_ff);
            state_in   = MUL_GO;
         end
         MUL_GO: begin
            mul_ctl.start = 1'b1;
            state_in = MUL_WAIT;
         end
         MUL_WAIT: if (mul_done) begin
            acc_in = prod;
            if (func_ff == agcm_pkg::FUNC_FINISH) begin
               aes_ctl  = '{start: 1'b1, block: {nonce_ff[127:32], 32'd1}};
               state_in = FIN_AES;
            end else if (func_ff == agcm_pkg::FUNC_TEXT) state_in = EMIT;
            else state_in = IDLE;
         end
         FIN_AES: if (aes_done) begin
            res_in     = acc_ff ^ aes_res;
            acc_in     = '0;
            ctr_in     = 32'd2;
            aad_tot_in = '0;
            txt_tot_in = '0;
            state_in   = EMIT;
         end
         // Hold the result until the output register is free
         EMIT: if (!rv_ff || rsp_tready) begin
            rv_in = 1'b1;
            if (func_ff == agcm_pkg::FUNC_FINISH) begin
               rd_in = {3'd0, 5'd16, res_ff[63:0], res_ff[127:64]};
               ru_in = {!enc_ff && (res_ff == exp_tag_ff), 1'b1};
            end else begin
               rd_in = {3'd0, n_ff, res_ff[63:0], res_ff[127:64]};
               ru_in = 2'b00;
            end
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
      // a key write forces a fresh schedule before the next word
      if (csr_valid && (csr_index == agcm_pkg::CSR_KEY_HIGH ||
                        csr_index == agcm_pkg::CSR_KEY_LOW))
         keys_ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         keys_ready_ff <= 1'b0;
         rv_ff <= 1'b0;
         acc_ff <= '0;
         ctr_ff <= 32'd2;
         aad_tot_ff <= '0;
         txt_tot_ff <= '0;
         key_ff <= '0;
         nonce_ff <= '0;
         enc_ff <= 1'b1;
         exp_tag_ff <= '0;
      end else begin
         state_ff <= state_in;
         keys_ready_ff <= keys_ready_in;
         rv_ff <= rv_in;
         acc_ff <= acc_in;
         ctr_ff <= ctr_in;
         aad_tot_ff <= aad_tot_in;
         txt_tot_ff <= txt_tot_in;
         if (csr_valid) begin
            unique case (csr_index)
               agcm_pkg::CSR_KEY_HIGH: key_ff[127:64]     <= csr_data;
               agcm_pkg::CSR_KEY_LOW:  key_ff[63:0]       <= csr_data;
               agcm_pkg::CSR_NONCE_HI: nonce_ff[127:64]   <= csr_data;
               agcm_pkg::CSR_NONCE_LO: nonce_ff[63:32]    <= csr_data[31:0];
               agcm_pkg::CSR_ENCRYPT:  enc_ff             <= csr_data[0];
               agcm_pkg::CSR_TAG_HIGH: exp_tag_ff[127:64] <= csr_data;
               agcm_pkg::CSR_TAG_LOW:  exp_tag_ff[63:0]   <= csr_data;
               default: ;
            endcase
         end
      end
      h_ff <= h_in; func_ff <= func_in; blk_ff <= blk_in; n_ff <= n_in;
      res_ff <= res_in; rd_ff <= rd_in; ru_ff <= ru_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;

   // A finished result waits while the output register is held
   a_emit_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == EMIT && rv_ff && !rsp_tready |=> state_ff == EMIT)
      else $error("result overwritten under stall");
   // A result holds until taken
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff && $stable(rd_ff))
      else $error("result dropped under stall");
   // Keys are valid whenever the data path starts work
   a_keys_before_use: assert property (@(posedge clock) disable iff (reset)
      state_ff == DISPATCH |-> keys_ready_ff) else $error("keys not ready");
   // A tag result always reports sixteen bytes
   a_tag_len: assert property (@(posedge clock) disable iff (reset)
      rv_ff && ru_ff[0] |-> rd_ff[132:128] == 5'd16) else $error("tag length");

endmodule
